// ===== rtl/tcbt_pkg.sv =====
`default_nettype none

package tcbt_pkg;

  // Phase slots carried by the ports; a build may use fewer
  localparam int unsigned NUM_SLOTS = 3;
  localparam int unsigned SLOT_W    = 2;
  localparam int unsigned QDEPTH    = 2;

  localparam int unsigned CUR_W   = 16;
  localparam int unsigned VOLT_W  = 16;
  localparam int unsigned REACT_W = 32;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CIDX_W  = 2;
  // 5*I*V and 6*Q both fit a 37-bit signed word
  localparam int unsigned CMP_W   = 37;

  localparam logic [CIDX_W-1:0] CFG_VLOSS_THRESH       = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_ENABLE_DELAY_TICKS = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_TRIP_DELAY_TICKS   = 2'd2;

  localparam logic [CFG_W-1:0] VLOSS_THRESH_RST       = 16'd0;
  localparam logic [CFG_W-1:0] ENABLE_DELAY_TICKS_RST = 16'd100;
  localparam logic [CFG_W-1:0] TRIP_DELAY_TICKS_RST   = 16'd500;

  typedef struct packed {
    logic [CFG_W-1:0] vloss_thresh;
    logic [CFG_W-1:0] enable_delay_ticks;
    logic [CFG_W-1:0] trip_delay_ticks;
  } cfg_t;

  // Classified tick handed from the front to the back
  typedef struct packed {
    logic                 start_ok;
    logic [NUM_SLOTS-1:0] out_band;
  } class_t;

endpackage

`default_nettype wire

// ===== rtl/tcbt_if.sv =====
`default_nettype none

interface tcbt_item_if;
  logic               valid;
  logic               ready;
  logic [15:0]        current_ab;
  logic [15:0]        current_bc;
  logic [15:0]        current_ca;
  logic [15:0]        voltage_ab;
  logic [15:0]        voltage_bc;
  logic [15:0]        voltage_ca;
  logic signed [31:0] reactive_ab;
  logic signed [31:0] reactive_bc;
  logic signed [31:0] reactive_ca;
  logic               regulation_on;
  logic               started;
  logic               manual_angle_mode;

  modport source (
    output valid, current_ab, current_bc, current_ca, voltage_ab, voltage_bc, voltage_ca,
           reactive_ab, reactive_bc, reactive_ca, regulation_on, started, manual_angle_mode,
    input  ready
  );
  modport sink (
    input  valid, current_ab, current_bc, current_ca, voltage_ab, voltage_bc, voltage_ca,
           reactive_ab, reactive_bc, reactive_ca, regulation_on, started, manual_angle_mode,
    output ready
  );
endinterface

interface tcbt_result_if;
  logic valid;
  logic ready;
  logic checking;
  logic pick_ab;
  logic pick_bc;
  logic pick_ca;
  logic trip_ab;
  logic trip_bc;
  logic trip_ca;

  modport source (
    output valid, checking, pick_ab, pick_bc, pick_ca, trip_ab, trip_bc, trip_ca,
    input  ready
  );
  modport sink (
    input  valid, checking, pick_ab, pick_bc, pick_ca, trip_ab, trip_bc, trip_ca,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/three_phase_current_band_trip.sv =====
// Channel  Dir  Handshake      Carries
// item_i   in   valid/ready    currents, voltages, reactive refs, mode flags
// result_o out  valid/ready    checking, picks and latched trips per phase
// cfg      in   cfg_we_i       register index and 16-bit data, no read-back
//
// In the front, one product a cycle goes through the shared 16x16 multiplier,
// each phase's compare following in the next cycle, and a new item is taken
// in the cycle the previous one is queued. The back updates the on-delays and
// trip latches once for each item it pops from the queue.
// Reset clears the registers to 0/100/500 and the delay counters, delay flags and trips.
// A stalled result_o holds in its output register; the two-entry queue lets
// the front keep working until it fills.
`default_nettype none

module three_phase_current_band_trip #(
  parameter int unsigned PHASES = 3
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  tcbt_item_if.sink                          item_i,
  tcbt_result_if.source                      result_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [tcbt_pkg::CIDX_W-1:0]   cfg_idx_i,
  input  wire logic [tcbt_pkg::CFG_W-1:0]    cfg_data_i
);

  tcbt_pkg::cfg_t   cfg_q;
  logic             push;
  logic             full;
  logic             pop;
  logic             q_valid;
  tcbt_pkg::class_t push_data;
  tcbt_pkg::class_t pop_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.vloss_thresh       <= tcbt_pkg::VLOSS_THRESH_RST;
      cfg_q.enable_delay_ticks <= tcbt_pkg::ENABLE_DELAY_TICKS_RST;
      cfg_q.trip_delay_ticks   <= tcbt_pkg::TRIP_DELAY_TICKS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tcbt_pkg::CFG_VLOSS_THRESH:       cfg_q.vloss_thresh       <= cfg_data_i;
        tcbt_pkg::CFG_ENABLE_DELAY_TICKS: cfg_q.enable_delay_ticks <= cfg_data_i;
        tcbt_pkg::CFG_TRIP_DELAY_TICKS:   cfg_q.trip_delay_ticks   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  tcbt_front #(
    .PHASES (PHASES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_i),
    .cfg_i       (cfg_q),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  tcbt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (pop_data)
  );

  tcbt_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (q_valid),
    .data_i   (pop_data),
    .pop_o    (pop),
    .cfg_i    (cfg_q),
    .result_o (result_o)
  );

endmodule

`default_nettype wire

// ===== rtl/tcbt_front.sv =====
`default_nettype none

module tcbt_front #(
  parameter int unsigned PHASES = 3
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  tcbt_item_if.sink             item_i,
  input  wire tcbt_pkg::cfg_t   cfg_i,
  input  wire logic             full_i,
  output logic                  push_o,
  output tcbt_pkg::class_t      push_data_o
);

  localparam int unsigned StepW = $clog2(PHASES + 1);
  localparam logic [StepW-1:0] LastStep = StepW'(PHASES);

  logic                 busy_q;
  logic [StepW-1:0]     step_q;
  logic [15:0]          cur_q   [tcbt_pkg::NUM_SLOTS];
  logic [15:0]          volt_q  [tcbt_pkg::NUM_SLOTS];
  logic signed [31:0]   react_q [tcbt_pkg::NUM_SLOTS];
  logic                 start_ok_q;

  logic [31:0]                           prod_q;
  logic signed [tcbt_pkg::CMP_W-1:0]     q6_q;
  logic signed [tcbt_pkg::CMP_W-1:0]     q4_q;
  logic                                  lim_ok_q;
  logic [tcbt_pkg::NUM_SLOTS-1:0]        oob_q;
  logic [tcbt_pkg::NUM_SLOTS-1:0]        oob_d;

  logic                                  fire;
  logic                                  at_last;
  logic                                  mul_en;
  logic [tcbt_pkg::SLOT_W-1:0]           mul_idx;
  logic [tcbt_pkg::SLOT_W-1:0]           cmp_idx;
  logic signed [tcbt_pkg::CMP_W-1:0]     q_ext;
  logic signed [tcbt_pkg::CMP_W-1:0]     lhs;
  logic                                  cmp_oob;

  assign at_last = busy_q && (step_q == LastStep);
  assign push_o  = at_last && !full_i;
  // Take the next item in the cycle the current one leaves
  assign item_i.ready = !busy_q || push_o;
  assign fire    = item_i.valid && item_i.ready;

  assign mul_en  = busy_q && (step_q < LastStep);
  assign mul_idx = tcbt_pkg::SLOT_W'(step_q);
  assign cmp_idx = tcbt_pkg::SLOT_W'(step_q - StepW'(1));

  assign q_ext = tcbt_pkg::CMP_W'(react_q[mul_idx]);
  assign lhs   = $signed({3'b000, prod_q, 2'b00}) + $signed({5'b00000, prod_q});
  assign cmp_oob = lim_ok_q && ((lhs > q6_q) || (lhs < q4_q));

  always_comb begin
    oob_d = oob_q;
    if (busy_q && (step_q != '0)) begin
      oob_d[cmp_idx] = cmp_oob;
    end
  end

  assign push_data_o.start_ok = start_ok_q;
  assign push_data_o.out_band = oob_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      oob_q  <= '0;
    end else if (fire) begin
      busy_q <= 1'b1;
      step_q <= '0;
      oob_q  <= '0;
    end else if (busy_q) begin
      oob_q <= oob_d;
      if (mul_en) begin
        step_q <= step_q + StepW'(1);
      end else if (!full_i) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Hold the item's payload while the phases go through the multiplier
  always_ff @(posedge clk_i) begin
    if (fire) begin
      cur_q[0]   <= item_i.current_ab;
      cur_q[1]   <= item_i.current_bc;
      cur_q[2]   <= item_i.current_ca;
      volt_q[0]  <= item_i.voltage_ab;
      volt_q[1]  <= item_i.voltage_bc;
      volt_q[2]  <= item_i.voltage_ca;
      react_q[0] <= item_i.reactive_ab;
      react_q[1] <= item_i.reactive_bc;
      react_q[2] <= item_i.reactive_ca;
      start_ok_q <= !item_i.regulation_on && item_i.started && !item_i.manual_angle_mode;
    end
  end

  // One phase a cycle: product and scaled reference now, compare next cycle
  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      prod_q   <= 32'(cur_q[mul_idx]) * 32'(volt_q[mul_idx]);
      q4_q     <= q_ext <<< 2;
      q6_q     <= (q_ext <<< 2) + (q_ext <<< 1);
      lim_ok_q <= volt_q[mul_idx] > cfg_i.vloss_thresh;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tcbt_queue.sv =====
`default_nettype none

module tcbt_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire tcbt_pkg::class_t data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output tcbt_pkg::class_t      data_o
);

  localparam int unsigned PtrW = $clog2(tcbt_pkg::QDEPTH);
  localparam int unsigned CntW = $clog2(tcbt_pkg::QDEPTH + 1);

  tcbt_pkg::class_t  mem_q [tcbt_pkg::QDEPTH];
  logic [PtrW-1:0]   wr_q;
  logic [PtrW-1:0]   rd_q;
  logic [CntW-1:0]   cnt_q;
  logic              do_push;
  logic              do_pop;

  assign full_o  = cnt_q == CntW'(tcbt_pkg::QDEPTH);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(tcbt_pkg::QDEPTH - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(tcbt_pkg::QDEPTH - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tcbt_back.sv =====
`default_nettype none

module tcbt_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  input  wire tcbt_pkg::class_t data_i,
  output logic                  pop_o,
  input  wire tcbt_pkg::cfg_t   cfg_i,
  tcbt_result_if.source         result_o
);

  typedef struct packed {
    logic [15:0] count;
    logic        flag;
  } dly_t;

  // On-delay: clear while low, set once the count has reached the delay
  function automatic dly_t dly_step(input logic in, input logic prev,
                                    input logic [15:0] count, input logic [15:0] delay);
    dly_t r;
    r.count = count;
    r.flag  = prev;
    if (!in) begin
      r.count = '0;
      r.flag  = 1'b0;
    end else if (count >= delay) begin
      r.flag = 1'b1;
    end else begin
      r.count = count + 16'd1;
    end
    return r;
  endfunction

  logic [15:0]                    en_cnt_q;
  logic                           en_flag_q;
  logic [15:0]                    pcnt_q [tcbt_pkg::NUM_SLOTS];
  logic [tcbt_pkg::NUM_SLOTS-1:0] pdel_q;
  logic [tcbt_pkg::NUM_SLOTS-1:0] trip_q;

  dly_t                           en_d;
  dly_t                           pd_d [tcbt_pkg::NUM_SLOTS];
  logic [tcbt_pkg::NUM_SLOTS-1:0] pick_d;
  logic [tcbt_pkg::NUM_SLOTS-1:0] trip_d;

  logic                           out_valid_q;
  logic                           out_chk_q;
  logic [tcbt_pkg::NUM_SLOTS-1:0] out_pick_q;

  assign pop_o = valid_i && (!out_valid_q || result_o.ready);

  always_comb begin
    en_d = dly_step(data_i.start_ok, en_flag_q, en_cnt_q, cfg_i.enable_delay_ticks);
    for (int p = 0; p < tcbt_pkg::NUM_SLOTS; p++) begin
      pick_d[p] = data_i.out_band[p] && en_d.flag;
      pd_d[p]   = dly_step(pick_d[p], pdel_q[p], pcnt_q[p], cfg_i.trip_delay_ticks);
      trip_d[p] = trip_q[p] || pd_d[p].flag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_cnt_q    <= '0;
      en_flag_q   <= 1'b0;
      pdel_q      <= '0;
      trip_q      <= '0;
      out_valid_q <= 1'b0;
      for (int p = 0; p < tcbt_pkg::NUM_SLOTS; p++) begin
        pcnt_q[p] <= '0;
      end
    end else if (pop_o) begin
      en_cnt_q    <= en_d.count;
      en_flag_q   <= en_d.flag;
      trip_q      <= trip_d;
      out_valid_q <= 1'b1;
      for (int p = 0; p < tcbt_pkg::NUM_SLOTS; p++) begin
        pcnt_q[p] <= pd_d[p].count;
        pdel_q[p] <= pd_d[p].flag;
      end
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_chk_q  <= en_d.flag;
      out_pick_q <= pick_d;
    end
  end

  assign result_o.valid    = out_valid_q;
  assign result_o.checking = out_chk_q;
  assign result_o.pick_ab  = out_pick_q[0];
  assign result_o.pick_bc  = out_pick_q[1];
  assign result_o.pick_ca  = out_pick_q[2];
  // Trip flags only change on a pop, so the live latch equals the held result
  assign result_o.trip_ab  = trip_q[0];
  assign result_o.trip_bc  = trip_q[1];
  assign result_o.trip_ca  = trip_q[2];

endmodule

`default_nettype wire

// ===== rtl/tcbt_checker.sv =====
`default_nettype none

module tcbt_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic       checking_i,
  input wire logic [2:0] pick_i,
  input wire logic [2:0] trip_i
);

  logic       in_fire;
  logic       out_fire;
  logic [2:0] pending_q;
  logic [2:0] seen_trip_q;

  assign in_fire  = in_valid_i && in_ready_i;
  assign out_fire = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q   <= '0;
      seen_trip_q <= '0;
    end else begin
      if (in_fire && !out_fire) begin
        pending_q <= pending_q + 3'd1;
      end else if (out_fire && !in_fire) begin
        pending_q <= pending_q - 3'd1;
      end
      if (out_fire) begin
        seen_trip_q <= seen_trip_q | trip_i;
      end
    end
  end

  // No result without an item accepted for it
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (pending_q != 3'd0))
    else $error("result shown with no item outstanding");

  // A phase may pick only while checking is on
  a_pick_gated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (pick_i != 3'b000)) |-> checking_i)
    else $error("pick without checking");

  // Trips stay latched across results
  a_trip_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire |-> ((trip_i & seen_trip_q) == seen_trip_q))
    else $error("latched trip dropped");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(checking_i) && $stable(pick_i) && $stable(trip_i)))
    else $error("stalled result changed");

endmodule

bind three_phase_current_band_trip tcbt_checker u_tcbt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (item_i.valid),
  .in_ready_i  (item_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .checking_i  (result_o.checking),
  .pick_i      ({result_o.pick_ca, result_o.pick_bc, result_o.pick_ab}),
  .trip_i      ({result_o.trip_ca, result_o.trip_bc, result_o.trip_ab})
);

`default_nettype wire
